FILE: sv/gdma_pkg.sv
// Shared types, codes and helpers of the general DMA channel engine.
`default_nettype none

package gdma_pkg;

	localparam int CHANNELS_DEF         = 8;
	localparam int REGS_PER_CHANNEL_DEF = 16;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_COPY  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [7:0] ADDR_START = 8'd128;

	// offsets inside one channel's register block
	localparam logic [2:0] OFF_CTRL = 3'd0;
	localparam logic [2:0] OFF_BBAD = 3'd1;
	localparam logic [2:0] OFF_AL   = 3'd2;
	localparam logic [2:0] OFF_AH   = 3'd3;
	localparam logic [2:0] OFF_AB   = 3'd4;
	localparam logic [2:0] OFF_CL   = 3'd5;
	localparam logic [2:0] OFF_CH   = 3'd6;

	localparam logic [2:0] MODE_SINGLE = 3'd0;
	localparam logic [2:0] MODE_ALT    = 3'd1;
	localparam logic [2:0] MODE_PAIR   = 3'd2;
	localparam logic [2:0] MODE_PAIR_B = 3'd6;

	localparam logic [1:0] STEP_INC = 2'd0;
	localparam logic [1:0] STEP_DEC = 2'd2;

	localparam logic [7:0] B_PAGE = 8'h21;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  read_data;
		logic [23:0] src_address;
		logic [23:0] dest_address;
		logic        last;
	} rsp_t;

	// A-bus step: low 16 bits wrap, bank is kept by the caller
	function automatic logic [15:0] step16(input logic [15:0] a, input logic [1:0] s);
		logic [15:0] r;
		case (s)
			STEP_INC: r = a + 16'd1;
			STEP_DEC: r = a - 16'd1;
			default:  r = a;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/gdma_req_if.sv
// Request channel into the engine: operation, register address and data.
`default_nettype none

interface gdma_req_if;
	import gdma_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/gdma_rsp_if.sv
// Result channel out of the engine: read data, byte copies and errors.
`default_nettype none

interface gdma_rsp_if;
	import gdma_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/gdma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module gdma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/general_dma_channel_engine.sv
// General DMA channel engine: top level with register file RAM and step sequencer.
//
// cmd carries requests: register read, register write or one engine tick.
// rsp carries results: read data, byte copy (src, dest) or mode error; last
// marks the final result of a request.
// One request is worked on at a time; cmd.ready is high while the sequencer
// is idle. The single-port register file RAM is why a start reads seven
// channel bytes one per cycle and a copy reads A low/high and writes back
// A low/high and the count, one byte per cycle.
// A result sits in the output register until rsp.ready; the sequencer stalls
// only when it has the next result and that register is still full, so the
// following request is taken while the last result waits.
// Reset (arst_n low) clears the enable mask, running channel and counters;
// per-entry valid bits make the whole register file read as zero at once,
// no clearing pass is needed.
`default_nettype none

module general_dma_channel_engine #(
	parameter int CHANNELS         = gdma_pkg::CHANNELS_DEF,
	parameter int REGS_PER_CHANNEL = gdma_pkg::REGS_PER_CHANNEL_DEF
) (
	input logic        clk,
	input logic        arst_n,
	gdma_req_if.sink   cmd,
	gdma_rsp_if.source rsp
);
	import gdma_pkg::*;

	localparam int DEPTH = CHANNELS * REGS_PER_CHANNEL;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDATA,
		S_START,
		S_CRD,
		S_EMIT1,
		S_EMIT2,
		S_WB,
		S_ERR
	} state_t;

	state_t      state_q;
	logic [3:0]  k_q;
	logic [7:0]  en_q;
	logic        run_q;
	logic [CW-1:0] ch_q;
	logic [5:0]  mode_q;
	logic [7:0]  bb_q;
	logic [15:0] cnt_q;
	logic [23:0] atmp_q;
	logic [23:0] src_q;
	logic [23:0] dst_q;
	logic        rdz_q;
	logic        rpend_q;
	logic [2:0]  roff_q;
	logic        rvld_q;
	logic [DEPTH-1:0] vld_q;
	logic        ov_q;
	rsp_t        od_q;

	logic          accept;
	logic          oslot;
	logic          emit;
	logic          in_file;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_q;
	logic [7:0]    rdata;
	logic [2:0]    rd_off;
	logic [2:0]    wr_off;
	logic [AW-1:0] chan_base;
	logic [7:0]    en_after;
	logic [CW-1:0] pick_ch;
	logic          pick_hit;
	logic          two;
	logic          mode_ok;
	logic          dir;
	logic [1:0]    stp;
	logic [23:0]   b_base;
	logic [23:0]   b_next;
	logic [23:0]   src_step;
	logic [23:0]   dst_step;
	logic [15:0]   a_step;

	gdma_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_q)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign rsp.valid = ov_q;
	assign rsp.data  = od_q;

	assign accept  = cmd.valid && (state_q == S_IDLE);
	assign oslot   = !ov_q || rsp.ready;
	assign emit    = oslot && (state_q inside {S_RDATA, S_EMIT1, S_EMIT2, S_ERR});
	assign in_file = ({1'b0, cmd.data.reg_addr} < 9'(DEPTH));
	// never-written entries read as zero
	assign rdata   = rvld_q ? ram_q : 8'd0;

	assign chan_base = AW'(int'(ch_q) * REGS_PER_CHANNEL);

	assign dir     = mode_q[5];
	assign stp     = mode_q[4:3];
	assign mode_ok = mode_q[2:0] inside {MODE_SINGLE, MODE_ALT, MODE_PAIR, MODE_PAIR_B};
	assign two     = (mode_q[2:0] != MODE_SINGLE) && (cnt_q >= 16'd2);
	assign b_base  = {8'h00, B_PAGE, bb_q};
	assign b_next  = b_base + 24'd1;
	assign a_step  = step16(atmp_q[15:0], stp);
	assign src_step = dir ? src_q : {src_q[23:16], step16(src_q[15:0], stp)};
	assign dst_step = dir ? {dst_q[23:16], step16(dst_q[15:0], stp)} : dst_q;

	// a finished channel drops out of the mask before the next one is picked
	assign en_after = (run_q && (cnt_q == 16'd0)) ? (en_q & ~(8'd1 << ch_q)) : en_q;

	always_comb begin
		pick_ch  = '0;
		pick_hit = 1'b0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (en_after[i]) begin
				pick_ch  = CW'(i);
				pick_hit = 1'b1;
			end
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		rd_off    = k_q[2:0];
		wr_off    = OFF_AL;
		case (state_q)
			S_IDLE: begin
				if (accept && in_file) begin
					if (cmd.data.operation == OP_READ) begin
						ram_re    = 1'b1;
						ram_raddr = cmd.data.reg_addr[AW-1:0];
					end else if (cmd.data.operation == OP_WRITE) begin
						ram_we    = 1'b1;
						ram_waddr = cmd.data.reg_addr[AW-1:0];
						ram_wdata = cmd.data.write_data;
					end
				end
			end
			S_START: begin
				// offsets CTRL..CH are read in order, one per cycle
				if (k_q < 4'd7) begin
					ram_re    = 1'b1;
					rd_off    = k_q[2:0];
					ram_raddr = chan_base + AW'(rd_off);
				end
			end
			S_CRD: begin
				if (k_q < 4'd2) begin
					ram_re    = 1'b1;
					rd_off    = (k_q == 4'd0) ? OFF_AL : OFF_AH;
					ram_raddr = chan_base + AW'(rd_off);
				end
			end
			S_WB: begin
				ram_we = 1'b1;
				case (k_q[1:0])
					2'd0: begin
						wr_off    = OFF_AL;
						ram_wdata = atmp_q[7:0];
					end
					2'd1: begin
						wr_off    = OFF_AH;
						ram_wdata = atmp_q[15:8];
					end
					2'd2: begin
						wr_off    = OFF_CL;
						ram_wdata = cnt_q[7:0];
					end
					default: begin
						wr_off    = OFF_CH;
						ram_wdata = cnt_q[15:8];
					end
				endcase
				ram_waddr = chan_base + AW'(wr_off);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			en_q    <= '0;
			run_q   <= 1'b0;
			ch_q    <= '0;
			mode_q  <= '0;
			bb_q    <= '0;
			cnt_q   <= '0;
			atmp_q  <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			rdz_q   <= 1'b0;
			rpend_q <= 1'b0;
			roff_q  <= '0;
			rvld_q  <= 1'b0;
			vld_q   <= '0;
			ov_q    <= 1'b0;
			od_q    <= '0;
		end else begin
			if (emit)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;

			rpend_q <= ram_re;
			if (ram_re) begin
				roff_q <= rd_off;
				rvld_q <= vld_q[ram_raddr];
			end
			if (ram_we)
				vld_q[ram_waddr] <= 1'b1;

			// capture channel bytes fetched by the start and copy sequences
			if (rpend_q && (state_q == S_START || state_q == S_CRD)) begin
				case (roff_q)
					OFF_CTRL: mode_q         <= {rdata[7], rdata[4:0]};
					OFF_BBAD: bb_q           <= rdata;
					OFF_AL:   atmp_q[7:0]    <= rdata;
					OFF_AH:   atmp_q[15:8]   <= rdata;
					OFF_AB:   atmp_q[23:16]  <= rdata;
					OFF_CL:   cnt_q[7:0]     <= rdata;
					OFF_CH:   cnt_q[15:8]    <= rdata;
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.data.operation)
							OP_READ: begin
								rdz_q   <= !in_file;
								state_q <= S_RDATA;
							end
							OP_WRITE: begin
								if (cmd.data.reg_addr == ADDR_START)
									en_q <= cmd.data.write_data;
							end
							OP_TICK: begin
								if (en_q != 8'd0) begin
									if (run_q && (cnt_q != 16'd0)) begin
										if (mode_ok) begin
											k_q     <= '0;
											state_q <= S_CRD;
										end else begin
											en_q    <= en_q & ~(8'd1 << ch_q);
											run_q   <= 1'b0;
											state_q <= S_ERR;
										end
									end else begin
										en_q  <= en_after;
										run_q <= pick_hit;
										ch_q  <= pick_ch;
										if (pick_hit) begin
											k_q     <= '0;
											state_q <= S_START;
										end
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_RDATA: begin
					if (oslot) begin
						od_q    <= '{kind: KIND_READ, read_data: rdz_q ? 8'd0 : rdata,
							src_address: 24'd0, dest_address: 24'd0, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				S_START: begin
					if (k_q == 4'd8) begin
						// a zero count leaves the copy addresses as they were
						if (cnt_q != 16'd0) begin
							if (dir) begin
								src_q <= b_base;
								dst_q <= atmp_q;
							end else begin
								src_q <= atmp_q;
								dst_q <= b_base;
							end
						end
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_CRD: begin
					if (k_q == 4'd2)
						state_q <= S_EMIT1;
					else
						k_q <= k_q + 4'd1;
				end
				S_EMIT1: begin
					if (oslot) begin
						od_q   <= '{kind: KIND_COPY, read_data: 8'd0, src_address: src_q,
							dest_address: dst_q, last: !two};
						// mode 1 alternates the B address on the second byte
						src_q  <= (two && (mode_q[2:0] == MODE_ALT) && dir) ? b_next : src_step;
						dst_q  <= (two && (mode_q[2:0] == MODE_ALT) && !dir) ? b_next : dst_step;
						atmp_q[15:0] <= a_step;
						cnt_q  <= cnt_q - (two ? 16'd2 : 16'd1);
						k_q     <= '0;
						state_q <= two ? S_EMIT2 : S_WB;
					end
				end
				S_EMIT2: begin
					if (oslot) begin
						od_q   <= '{kind: KIND_COPY, read_data: 8'd0, src_address: src_q,
							dest_address: dst_q, last: 1'b1};
						src_q  <= ((mode_q[2:0] == MODE_ALT) && dir) ? b_base : src_step;
						dst_q  <= ((mode_q[2:0] == MODE_ALT) && !dir) ? b_base : dst_step;
						atmp_q[15:0] <= a_step;
						k_q     <= '0;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (k_q == 4'd3)
						state_q <= S_IDLE;
					else
						k_q <= k_q + 4'd1;
				end
				S_ERR: begin
					if (oslot) begin
						od_q    <= '{kind: KIND_ERROR, read_data: 8'd0, src_address: 24'd0,
							dest_address: 24'd0, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/gdma_transfer_checker.sv
// Watches both channels of the DMA engine, predicts its results and compares them.
`default_nettype none

module gdma_transfer_checker (
	input  logic clk,
	input  logic arst_n,
	gdma_req_if  cmd,
	gdma_rsp_if  rsp,
	output int   fail_count,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import gdma_pkg::*;

	localparam int NCH      = CHANNELS_DEF;
	localparam int RPC      = REGS_PER_CHANNEL_DEF;
	localparam int REG_FILE = NCH * RPC;
	localparam int NO_CHAN  = NCH;

	logic [7:0]  reg_img [REG_FILE];
	logic [23:0] a_addr [NCH];
	logic [15:0] count_m [NCH];
	logic [5:0]  mode_m [NCH];
	logic [7:0]  en_mask;
	int          run_ch;
	logic [23:0] cur_src;
	logic [23:0] cur_dst;
	logic [23:0] b_addr;
	rsp_t        due_q [$];

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	function automatic void clear_engine();
		foreach (reg_img[i]) reg_img[i] = 8'h00;
		for (int i = 0; i < NCH; i++) begin
			a_addr[i] = '0;
			count_m[i] = '0;
			mode_m[i] = '0;
		end
		en_mask = '0;
		run_ch = NO_CHAN;
		cur_src = '0;
		cur_dst = '0;
		b_addr = '0;
		due_q.delete();
	endfunction

	function automatic void post(input logic [1:0] k, input logic [7:0] rd,
			input logic [23:0] src, input logic [23:0] dst, input logic last);
		rsp_t r;
		r.kind = k;
		r.read_data = rd;
		r.src_address = src;
		r.dest_address = dst;
		r.last = last;
		due_q.push_back(r);
	endfunction

	// 16-bit wrap inside the bank
	function automatic logic [23:0] next_a(input logic [23:0] a, input logic [1:0] s);
		if (s == STEP_INC)
			return {a[23:16], a[15:0] + 16'd1};
		if (s == STEP_DEC)
			return {a[23:16], a[15:0] - 16'd1};
		return a;
	endfunction

	function automatic void walk_a(input int ch);
		logic [1:0] s;
		s = mode_m[ch][4:3];
		if (mode_m[ch][5])
			cur_dst = next_a(cur_dst, s);
		else
			cur_src = next_a(cur_src, s);
		a_addr[ch] = next_a(a_addr[ch], s);
		reg_img[ch * RPC + OFF_AL] = a_addr[ch][7:0];
		reg_img[ch * RPC + OFF_AH] = a_addr[ch][15:8];
	endfunction

	function automatic void set_b(input logic [23:0] v);
		if (mode_m[run_ch][5])
			cur_src = v;
		else
			cur_dst = v;
	endfunction

	function automatic void start_chan(input int ch);
		int base;
		base = ch * RPC;
		run_ch = ch;
		mode_m[ch] = {reg_img[base + OFF_CTRL][7], reg_img[base + OFF_CTRL][4:0]};
		b_addr = {8'h00, B_PAGE, reg_img[base + OFF_BBAD]};
		count_m[ch] = {reg_img[base + OFF_CH], reg_img[base + OFF_CL]};
		if (count_m[ch] == 16'd0)
			return;
		if (mode_m[ch][5]) begin
			cur_src = b_addr;
			cur_dst = a_addr[ch];
		end else begin
			cur_src = a_addr[ch];
			cur_dst = b_addr;
		end
	endfunction

	function automatic void copy_step();
		int ch;
		logic [2:0] m;
		ch = run_ch;
		m = mode_m[ch][2:0];
		if (m == MODE_SINGLE) begin
			post(KIND_COPY, 8'h00, cur_src, cur_dst, 1'b1);
			walk_a(ch);
			count_m[ch] = count_m[ch] - 16'd1;
		end else if (m == MODE_ALT || m == MODE_PAIR || m == MODE_PAIR_B) begin
			if (count_m[ch] >= 16'd2) begin
				post(KIND_COPY, 8'h00, cur_src, cur_dst, 1'b0);
				walk_a(ch);
				if (m == MODE_ALT)
					set_b(b_addr + 24'd1);
				post(KIND_COPY, 8'h00, cur_src, cur_dst, 1'b1);
				walk_a(ch);
				if (m == MODE_ALT)
					set_b(b_addr);
				count_m[ch] = count_m[ch] - 16'd2;
			end else begin
				post(KIND_COPY, 8'h00, cur_src, cur_dst, 1'b1);
				walk_a(ch);
				count_m[ch] = 16'd0;
			end
		end else begin
			// unsupported mode: drop the channel, count stays as it was
			post(KIND_ERROR, 8'h00, 24'h0, 24'h0, 1'b1);
			en_mask[ch] = 1'b0;
			run_ch = NO_CHAN;
			return;
		end
		reg_img[ch * RPC + OFF_CL] = count_m[ch][7:0];
		reg_img[ch * RPC + OFF_CH] = count_m[ch][15:8];
	endfunction

	function automatic void engine_tick();
		if (en_mask == 8'h00)
			return;
		if (run_ch < NCH) begin
			if (count_m[run_ch] != 16'd0) begin
				copy_step();
				return;
			end
			en_mask[run_ch] = 1'b0;
		end
		run_ch = NO_CHAN;
		for (int i = 0; i < NCH; i++) begin
			if (en_mask[i]) begin
				start_chan(i);
				return;
			end
		end
	endfunction

	function automatic void step_engine(input req_t q);
		int ch;
		int off;
		case (q.operation)
			OP_READ: begin
				if (q.reg_addr < REG_FILE)
					post(KIND_READ, reg_img[int'(q.reg_addr)], 24'h0, 24'h0, 1'b1);
				else
					post(KIND_READ, 8'h00, 24'h0, 24'h0, 1'b1);
			end
			OP_WRITE: begin
				if (q.reg_addr == ADDR_START) begin
					en_mask = q.write_data;
				end else if (q.reg_addr < REG_FILE) begin
					ch = q.reg_addr / RPC;
					off = q.reg_addr % RPC;
					reg_img[int'(q.reg_addr)] = q.write_data;
					if (off == OFF_AL)
						a_addr[ch][7:0] = q.write_data;
					else if (off == OFF_AH)
						a_addr[ch][15:8] = q.write_data;
					else if (off == OFF_AB)
						a_addr[ch][23:16] = q.write_data;
				end
			end
			OP_TICK: engine_tick();
			default: ;
		endcase
	endfunction

	task automatic cmp_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0d ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	task automatic check_rsp(input rsp_t got);
		rsp_t want;
		if (due_q.size() == 0) begin
			fail_count++;
			$display("%0d ns: result with none due, expected nothing, actual %h", $time, got);
		end else begin
			want = due_q.pop_front();
			cmp_field("kind", 24'(want.kind), 24'(got.kind));
			cmp_field("read_data", 24'(want.read_data), 24'(got.read_data));
			cmp_field("src_address", want.src_address, got.src_address);
			cmp_field("dest_address", want.dest_address, got.dest_address);
			cmp_field("last", 24'(want.last), 24'(got.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_engine();
			fail_count = 0;
		end else begin
			if (rsp.valid && rsp.ready)
				check_rsp(rsp.data);
			if (cmd.valid && cmd.ready)
				step_engine(cmd.data);
		end
		outstanding = due_q.size();
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb_general_dma_channel_engine.sv
// Top of the DMA engine testbench: clock, reset, request stimulus and verdict.
`default_nettype none

module tb_general_dma_channel_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import gdma_pkg::*;

	localparam int NCH          = CHANNELS_DEF;
	localparam int RPC          = REGS_PER_CHANNEL_DEF;
	localparam int REG_FILE     = NCH * RPC;
	localparam int LAST_CH      = NCH - 1;
	localparam int ITEM_GOAL    = 750;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 32;

	localparam logic [1:0] OP_SPARE  = 2'd3;
	localparam logic [7:0] ADDR_SCAN = ADDR_START + 8'd1;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   n_items;
	int   cycles;
	bit   idle_on = 1'b1;
	bit   hold_req = 1'b0;

	gdma_req_if cmd_if ();
	gdma_rsp_if rsp_if ();

	general_dma_channel_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	gdma_transfer_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_if),
		.rsp         (rsp_if),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= !(idle_on && $urandom_range(99) < 11);
			end
		end
	end

	task automatic send_req(input logic [1:0] op, input logic [7:0] addr,
			input logic [7:0] data);
		req_t q;
		q.operation = op;
		q.reg_addr = addr;
		q.write_data = data;
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 11) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data <= q;
		do @(posedge clk); while (!cmd_if.ready);
		if (op == OP_READ || op == OP_TICK ||
				(op == OP_WRITE && (addr == ADDR_START || addr < REG_FILE)))
			n_items++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		cmd_if.valid <= 1'b0;
		wait (outstanding == 0);
	endtask

	// program one to three channels, enable them and tick them through
	task automatic run_transfers();
		int n_ch;
		int ch;
		int base;
		int ticks;
		logic [7:0]  mask;
		logic [7:0]  bad_ch;
		logic [7:0]  ctrl;
		logic [2:0]  mode;
		logic [15:0] count;
		logic [23:0] a;
		mask = '0;
		bad_ch = '0;
		ticks = 1;
		n_ch = $urandom_range(3, 1);
		repeat (n_ch) begin
			ch = $urandom_range(LAST_CH);
			base = ch * RPC;
			if ($urandom_range(9) < 8) begin
				case ($urandom_range(3))
					0: mode = MODE_SINGLE;
					1: mode = MODE_ALT;
					2: mode = MODE_PAIR;
					default: mode = MODE_PAIR_B;
				endcase
				count = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(6, 1));
				ticks += count + 2;
			end else begin
				do mode = 3'($urandom); while (mode == MODE_SINGLE || mode == MODE_ALT ||
					mode == MODE_PAIR || mode == MODE_PAIR_B);
				count = 16'($urandom_range(16'hFFFF, 1));
				ticks += 2;
				bad_ch[ch] = 1'b1;
			end
			a = 24'($urandom);
			case ($urandom_range(3))
				0: a[15:0] = 16'hFFFF;
				1: a[15:0] = 16'h0000;
				default: ;
			endcase
			ctrl = 8'($urandom);
			ctrl[2:0] = mode;
			send_req(OP_WRITE, 8'(base + OFF_CTRL), ctrl);
			send_req(OP_WRITE, 8'(base + OFF_BBAD), 8'($urandom));
			send_req(OP_WRITE, 8'(base + OFF_AL), a[7:0]);
			send_req(OP_WRITE, 8'(base + OFF_AH), a[15:8]);
			send_req(OP_WRITE, 8'(base + OFF_AB), a[23:16]);
			send_req(OP_WRITE, 8'(base + OFF_CL), count[7:0]);
			send_req(OP_WRITE, 8'(base + OFF_CH), count[15:8]);
			if ($urandom_range(3) == 0)
				send_req(OP_WRITE, 8'(base + $urandom_range(RPC - 1, OFF_CH + 1)),
					8'($urandom));
			mask[ch] = 1'b1;
		end
		send_req(OP_WRITE, ADDR_START, mask);
		repeat (ticks) begin
			send_req(OP_TICK, 8'($urandom), 8'($urandom));
			case ($urandom_range(19))
				0, 1, 2: send_req(OP_READ,
					8'($urandom_range(LAST_CH) * RPC + $urandom_range(OFF_CH)), 8'($urandom));
				3: send_req(OP_WRITE, ADDR_START, 8'($urandom));
				default: ;
			endcase
		end
		// shorten counts left behind by error channels so they cannot stall later runs
		for (int i = 0; i < NCH; i++)
			if (bad_ch[i])
				send_req(OP_WRITE, 8'(i * RPC + OFF_CH), 8'h00);
	endtask

	task automatic send_noise();
		logic [1:0] op;
		logic [7:0] addr;
		logic [7:0] data;
		op = 2'($urandom);
		addr = $urandom_range(1) ? 8'($urandom_range(ADDR_SCAN)) : 8'($urandom);
		data = 8'($urandom);
		if (op == OP_WRITE && addr < REG_FILE && addr % RPC == OFF_CH)
			data = 8'h00;
		send_req(op, addr, data);
	endtask

	initial begin
		bit held;
		bit paused;
		held = 1'b0;
		paused = 1'b0;
		n_items = 0;
		cmd_if.valid = 1'b0;
		cmd_if.data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reads of reset, enable and unmapped space, ignored request, idle tick
		send_req(OP_READ, 8'h00, 8'h00);
		send_req(OP_READ, ADDR_START, 8'hFF);
		send_req(OP_READ, 8'hFF, 8'h00);
		send_req(OP_WRITE, ADDR_SCAN, 8'hFF);
		send_req(OP_SPARE, 8'h00, 8'hFF);
		send_req(OP_TICK, 8'h00, 8'h00);
		// ch0: B to A, decrement from 7E:0000 (wraps in bank), alternating B, 3 bytes
		send_req(OP_WRITE, 8'(OFF_CTRL), 8'h91);
		send_req(OP_WRITE, 8'(OFF_BBAD), 8'h80);
		send_req(OP_WRITE, 8'(OFF_AL), 8'h00);
		send_req(OP_WRITE, 8'(OFF_AH), 8'h00);
		send_req(OP_WRITE, 8'(OFF_AB), 8'h7E);
		send_req(OP_WRITE, 8'(OFF_CL), 8'h03);
		send_req(OP_WRITE, 8'(OFF_CH), 8'h00);
		// ch1 untouched (zero count), last channel in a reserved mode with full count
		send_req(OP_WRITE, 8'(LAST_CH * RPC + OFF_CTRL), 8'h07);
		send_req(OP_WRITE, 8'(LAST_CH * RPC + OFF_CL), 8'hFF);
		send_req(OP_WRITE, 8'(LAST_CH * RPC + OFF_CH), 8'hFF);
		send_req(OP_WRITE, ADDR_START, 8'h83);
		repeat (7) send_req(OP_TICK, 8'hFF, 8'hFF);
		send_req(OP_READ, 8'(LAST_CH * RPC + OFF_CH), 8'h00);
		send_req(OP_READ, 8'(OFF_AL), 8'h00);
		drain_results();
		send_req(OP_WRITE, 8'(LAST_CH * RPC + OFF_CH), 8'h00);

		while (n_items < ITEM_GOAL) begin
			idle_on = !(n_items >= 350 && n_items < 470);
			if (!held && n_items >= 200) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			if (!paused && n_items >= 550) begin
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(9) < 7)
				run_transfers();
			else
				repeat ($urandom_range(4, 1)) send_noise();
		end
		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
